### sv/crt_pkg.sv
// crt_pkg: shared types and codes for the chunk reassembly tracker.
// No dependencies; used by the interfaces, controller, datapath and checker.
package crt_pkg;

    localparam int CMD_W  = 3;
    localparam int STS_W  = 3;
    localparam int ID_W   = 8;
    localparam int IDX_W8 = 8;
    localparam int TIME_W = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_BEGIN  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RECORD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RESEND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NOTE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POLL   = 3'd5;

    // status codes
    localparam logic [STS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STS_W-1:0] ST_BUSY      = 3'd1;
    localparam logic [STS_W-1:0] ST_NO_ACTIVE = 3'd2;
    localparam logic [STS_W-1:0] ST_WRONG_REQ = 3'd3;
    localparam logic [STS_W-1:0] ST_INVALID   = 3'd4;
    localparam logic [STS_W-1:0] ST_DUPLICATE = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic scan_step;
        logic load_result;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic rec_ok;
        logic scan_done;
    } dp_sts_t;

endpackage

### sv/crt_req_if.sv
// crt_req_if: command item channel (valid/ready plus command fields).
// Depends on crt_pkg for field widths.
interface crt_req_if import crt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   xfer_id;
    logic [IDX_W8-1:0] chunk_index;
    logic [IDX_W8-1:0] chunk_total;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, command, xfer_id, chunk_index, chunk_total, now_ms,
                    input ready);
    modport sink   (input valid, command, xfer_id, chunk_index, chunk_total, now_ms,
                    output ready);
endinterface

### sv/crt_rsp_if.sv
// crt_rsp_if: result item channel (valid/ready plus result fields).
// Depends on crt_pkg for field widths.
interface crt_rsp_if import crt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [STS_W-1:0]  status;
    logic              complete;
    logic              new_chunk;
    logic [IDX_W8-1:0] next_needed;
    logic              resend_due;

    modport source (output valid, status, complete, new_chunk, next_needed, resend_due,
                    input ready);
    modport sink   (input valid, status, complete, new_chunk, next_needed, resend_due,
                    output ready);
endinterface

### sv/crt_ctrl.sv
// crt_ctrl: sequencing state machine for the tracker.
// Depends on crt_pkg; drives crt_datapath through ctl_cmd_t.
module crt_ctrl import crt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dp_sts_t  sts,
    output ctl_cmd_t ctl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next      = state_reg;
        ctl             = '0;
        req_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                ctl.capture = req_valid;
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.execute = 1'b1;
                state_next  = sts.rec_ok ? S_SCAN : S_RESULT;
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // wait for the output slot to free up
                if (!out_valid_reg || rsp_ready)
                begin
                    ctl.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (ctl.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

### sv/crt_datapath.sv
// crt_datapath: transfer state, received map, lowest-missing scan, result register.
// Depends on crt_pkg; sequenced by crt_ctrl.
module crt_datapath import crt_pkg::*;
#(
    parameter int MAX_CHUNKS = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [TIME_W-1:0] cfg_wr_data,
    input  ctl_cmd_t          ctl,
    output dp_sts_t           sts,
    input  logic [CMD_W-1:0]  command,
    input  logic [ID_W-1:0]   xfer_id,
    input  logic [IDX_W8-1:0] chunk_index,
    input  logic [IDX_W8-1:0] chunk_total,
    input  logic [TIME_W-1:0] now_ms,
    output logic [STS_W-1:0]  status,
    output logic              complete,
    output logic              new_chunk,
    output logic [IDX_W8-1:0] next_needed,
    output logic              resend_due
);

    localparam int              MAP_AW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam logic [IDX_W8-1:0] MAX_TOT = IDX_W8'(MAX_CHUNKS);

    // configuration and transfer state
    logic [TIME_W-1:0]     timeout_reg;
    logic                  active_reg,    active_next;
    logic [ID_W-1:0]       cur_req_reg,   cur_req_next;
    logic [IDX_W8-1:0]     known_tot_reg, known_tot_next;
    logic [IDX_W8-1:0]     next_miss_reg, next_miss_next;
    logic [TIME_W-1:0]     deadline_reg,  deadline_next;
    logic [MAX_CHUNKS-1:0] map_reg,       map_next;
    logic [IDX_W8-1:0]     scan_cnt_reg;

    // captured item
    logic [CMD_W-1:0]  cmd_reg;
    logic [ID_W-1:0]   rid_reg;
    logic [IDX_W8-1:0] idx_reg;
    logic [IDX_W8-1:0] tot_reg;
    logic [TIME_W-1:0] now_reg;

    // per-item outcome
    logic [STS_W-1:0] status_reg, status_next;
    logic             fresh_reg,  fresh_next;
    logic             rec_ok_reg, rec_ok_next;

    // result register
    logic [STS_W-1:0]  rsp_status_reg;
    logic              rsp_complete_reg;
    logic              rsp_fresh_reg;
    logic [IDX_W8-1:0] rsp_next_reg;
    logic              rsp_due_reg;

    logic [TIME_W-1:0] deadline_sum;
    logic              rec_bad;
    logic              idx_seen;
    logic              scan_done;
    logic              done_now;

    assign deadline_sum = now_reg + timeout_reg;
    assign rec_bad = (tot_reg == '0) || (idx_reg >= tot_reg) || (tot_reg > MAX_TOT)
                     || ((known_tot_reg != '0) && (known_tot_reg != tot_reg));
    assign idx_seen = map_reg[idx_reg[MAP_AW-1:0]];

    always_comb
    begin
        active_next    = active_reg;
        cur_req_next   = cur_req_reg;
        known_tot_next = known_tot_reg;
        next_miss_next = next_miss_reg;
        deadline_next  = deadline_reg;
        map_next       = map_reg;
        status_next    = ST_OK;
        fresh_next     = 1'b0;
        rec_ok_next    = 1'b0;
        unique case (cmd_reg)
            CMD_BEGIN:
            begin
                if (active_reg)
                begin
                    status_next = ST_BUSY;
                end
                else
                begin
                    map_next       = '0;
                    active_next    = 1'b1;
                    cur_req_next   = rid_reg;
                    known_tot_next = '0;
                    next_miss_next = '0;
                    deadline_next  = deadline_sum;
                end
            end
            CMD_RECORD:
            begin
                priority if (!active_reg)
                begin
                    status_next = ST_NO_ACTIVE;
                end
                else if (rid_reg != cur_req_reg)
                begin
                    status_next = ST_WRONG_REQ;
                end
                else if (rec_bad)
                begin
                    status_next = ST_INVALID;
                end
                else
                begin
                    rec_ok_next    = 1'b1;
                    known_tot_next = tot_reg;
                    deadline_next  = deadline_sum;
                    if (idx_seen)
                    begin
                        status_next = ST_DUPLICATE;
                    end
                    else
                    begin
                        map_next[idx_reg[MAP_AW-1:0]] = 1'b1;
                        fresh_next = 1'b1;
                    end
                end
            end
            CMD_RESEND:
            begin
                priority if (!active_reg)
                begin
                    status_next = ST_NO_ACTIVE;
                end
                else if ((known_tot_reg != '0) && (idx_reg >= known_tot_reg))
                begin
                    status_next = ST_INVALID;
                end
                else
                begin
                    next_miss_next = idx_reg;
                    deadline_next  = now_reg;
                end
            end
            CMD_NOTE:
            begin
                if (!active_reg)
                begin
                    status_next = ST_NO_ACTIVE;
                end
                else
                begin
                    deadline_next = deadline_sum;
                end
            end
            CMD_CLEAR:
            begin
                active_next    = 1'b0;
                cur_req_next   = '0;
                known_tot_next = '0;
                next_miss_next = '0;
                deadline_next  = '0;
                map_next       = '0;
            end
            default:
            begin
                // poll and the unused codes
                if (!active_reg)
                begin
                    status_next = ST_NO_ACTIVE;
                end
            end
        endcase
    end

    // one map bit per scan step; stops at the first gap or at the total
    assign done_now  = (scan_cnt_reg >= known_tot_reg);
    assign scan_done = done_now || !map_reg[scan_cnt_reg[MAP_AW-1:0]];

    assign sts.rec_ok    = (cmd_reg == CMD_RECORD) && active_reg && (rid_reg == cur_req_reg)
                           && !rec_bad;
    assign sts.scan_done = scan_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= '0;
            active_reg    <= 1'b0;
            cur_req_reg   <= '0;
            known_tot_reg <= '0;
            next_miss_reg <= '0;
            deadline_reg  <= '0;
            map_reg       <= '0;
            scan_cnt_reg  <= '0;
            status_reg    <= ST_OK;
            fresh_reg     <= 1'b0;
            rec_ok_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            if (ctl.execute)
            begin
                active_reg    <= active_next;
                cur_req_reg   <= cur_req_next;
                known_tot_reg <= known_tot_next;
                next_miss_reg <= next_miss_next;
                deadline_reg  <= deadline_next;
                map_reg       <= map_next;
                status_reg    <= status_next;
                fresh_reg     <= fresh_next;
                rec_ok_reg    <= rec_ok_next;
                scan_cnt_reg  <= '0;
            end
            else if (ctl.scan_step)
            begin
                if (scan_done)
                begin
                    next_miss_reg <= scan_cnt_reg;
                end
                else
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= command;
            rid_reg <= xfer_id;
            idx_reg <= chunk_index;
            tot_reg <= chunk_total;
            now_reg <= now_ms;
        end
        if (ctl.load_result)
        begin
            rsp_status_reg   <= status_reg;
            rsp_complete_reg <= rec_ok_reg && (next_miss_reg >= known_tot_reg);
            rsp_fresh_reg    <= fresh_reg;
            rsp_next_reg     <= next_miss_reg;
            rsp_due_reg      <= active_reg
                                && !((known_tot_reg != '0) && (next_miss_reg >= known_tot_reg))
                                && (now_reg >= deadline_reg);
        end
    end

    assign status      = rsp_status_reg;
    assign complete    = rsp_complete_reg;
    assign new_chunk   = rsp_fresh_reg;
    assign next_needed = rsp_next_reg;
    assign resend_due  = rsp_due_reg;

endmodule

### sv/chunk_reassembly_tracker.sv
// chunk_reassembly_tracker: top level, controller plus datapath.
// Depends on crt_pkg, crt_req_if, crt_rsp_if, crt_ctrl, crt_datapath.
//
// Usage notes:
//  - req (sink): one command item per handshake (valid & ready at a rising
//    edge). Commands: begin, record chunk, resend from, note resend, clear,
//    poll. Exactly one result item leaves on rsp per command item.
//  - rsp (source): status, complete, new_chunk, next_needed, resend_due.
//    The result sits in an output register; a stalled receiver holds it
//    there while the next command is already taken and executed. A finished
//    command only waits to load its result until the register is free.
//  - cfg_wr_en / cfg_wr_data: writes the resend timeout (ms). Write only
//    while no command is in flight.
//  - Sequencing: a non-record command passes through accept, execute and
//    result, with the result valid in the cycle after it is loaded. A
//    successful record adds a scan of the received map at one bit per cycle,
//    from index zero up to the lowest missing index (at most the announced
//    total). The single-bit map scan sets the rate.
//  - Reset (rst_n, async low): no transfer active, map and deadline zero,
//    timeout zero, no result pending.
module chunk_reassembly_tracker import crt_pkg::*;
#(
    parameter int MAX_CHUNKS = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [TIME_W-1:0] cfg_wr_data,
    crt_req_if.sink           req,
    crt_rsp_if.source         rsp
);

    ctl_cmd_t ctl;
    dp_sts_t  sts;

    // sequencing: idle -> execute -> (scan) -> result
    crt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // transfer state, received map and result register
    crt_datapath #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctl         (ctl),
        .sts         (sts),
        .command     (req.command),
        .xfer_id     (req.xfer_id),
        .chunk_index (req.chunk_index),
        .chunk_total (req.chunk_total),
        .now_ms      (req.now_ms),
        .status      (rsp.status),
        .complete    (rsp.complete),
        .new_chunk   (rsp.new_chunk),
        .next_needed (rsp.next_needed),
        .resend_due  (rsp.resend_due)
    );

endmodule

### sv/crt_checker.sv
// crt_checker: port-level checks for the tracker, bound to the top level.
// Depends on crt_pkg and chunk_reassembly_tracker.
module crt_checker import crt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [STS_W-1:0]  status,
    input logic              complete,
    input logic              new_chunk,
    input logic [IDX_W8-1:0] next_needed,
    input logic              resend_due
);

    // a result held under stall keeps its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(complete)
            && $stable(new_chunk) && $stable(next_needed) && $stable(resend_due))
        else $error("result changed under stall");

    // one command at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("back-to-back accept");

    a_complete_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && complete |-> (status == ST_OK) || (status == ST_DUPLICATE))
        else $error("complete with failing status");

    a_complete_no_resend: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && complete |-> !resend_due)
        else $error("resend due on complete transfer");

    a_new_chunk_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && new_chunk |-> status == ST_OK)
        else $error("new chunk with non-ok status");

endmodule

bind chunk_reassembly_tracker crt_checker u_crt_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .complete    (rsp.complete),
    .new_chunk   (rsp.new_chunk),
    .next_needed (rsp.next_needed),
    .resend_due  (rsp.resend_due)
);

### sim/tb_chunk_reassembly_tracker.sv
`timescale 1ns / 100ps
// tb_chunk_reassembly_tracker: self-checking bench for the chunk reassembly tracker.
// Needs crt_pkg, crt_req_if, crt_rsp_if and the tracker RTL; reads no files.
module tb_chunk_reassembly_tracker;
    import crt_pkg::*;

    localparam int N_CHUNKS       = 128;
    localparam int CYCLE_LIMIT    = 1_500_000;
    localparam int N_PHASES       = 6;
    localparam int PHASE_ITEMS    = 305;
    localparam int HOLD_AT_RESULT = 450;   // result count that triggers the long stall
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 20;

    // codes 6 and 7 have no meaning of their own and behave as poll
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ID_W-1:0]   xfer_id;
        logic [IDX_W8-1:0] chunk_index;
        logic [IDX_W8-1:0] chunk_total;
        logic [TIME_W-1:0] now_ms;
    } cmd_item_t;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic              complete;
        logic              new_chunk;
        logic [IDX_W8-1:0] next_needed;
        logic              resend_due;
    } rsp_item_t;

    // one directed row: the command, and the result when it is typed in by hand
    typedef struct packed {
        logic      typed;
        cmd_item_t cmd;
        rsp_item_t want;
    } dir_row_t;

    localparam rsp_item_t NO_RSP = '0;

    // Directed table, run with the timeout at its reset value of zero.
    // Typed rows are the ones readable at a glance: everything refused while
    // idle, the first begin, busy, the rejects before any chunk lands, and the clears.
    localparam dir_row_t DIRECTED [0:27] = '{
        // nothing active yet
        '{1'b1, '{CMD_POLL,   8'h00, 8'h00, 8'h00, 32'd0},
              '{ST_NO_ACTIVE, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{1'b1, '{CMD_RECORD, 8'h00, 8'h00, 8'h01, 32'd0},
              '{ST_NO_ACTIVE, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{1'b1, '{CMD_RESEND, 8'h00, 8'hFF, 8'h00, 32'd0},
              '{ST_NO_ACTIVE, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{1'b1, '{CMD_NOTE,   8'h00, 8'h00, 8'h00, 32'd0},
              '{ST_NO_ACTIVE, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{1'b1, '{CMD_CLEAR,  8'h00, 8'h00, 8'h00, 32'd0},
              '{ST_OK,        1'b0, 1'b0, 8'h00, 1'b0}},
        '{1'b1, '{CMD_SPARE6, 8'h00, 8'h00, 8'h00, 32'd0},
              '{ST_NO_ACTIVE, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{1'b1, '{CMD_SPARE7, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF},
              '{ST_NO_ACTIVE, 1'b0, 1'b0, 8'h00, 1'b0}},
        // open id 0xFF at t=100; deadline 100, so due right away
        '{1'b1, '{CMD_BEGIN,  8'hFF, 8'h00, 8'h00, 32'd100},
              '{ST_OK,        1'b0, 1'b0, 8'h00, 1'b1}},
        '{1'b1, '{CMD_BEGIN,  8'h00, 8'h00, 8'h00, 32'd50},
              '{ST_BUSY,      1'b0, 1'b0, 8'h00, 1'b0}},
        // rejects: wrong id, zero total, oversized totals, index at total
        '{1'b1, '{CMD_RECORD, 8'h00, 8'h00, 8'h01, 32'd60},
              '{ST_WRONG_REQ, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{1'b1, '{CMD_RECORD, 8'hFF, 8'h00, 8'h00, 32'd60},
              '{ST_INVALID,   1'b0, 1'b0, 8'h00, 1'b0}},
        '{1'b1, '{CMD_RECORD, 8'hFF, 8'hFF, 8'hFF, 32'd60},
              '{ST_INVALID,   1'b0, 1'b0, 8'h00, 1'b0}},
        '{1'b1, '{CMD_RECORD, 8'hFF, 8'd128, 8'd129, 32'd60},
              '{ST_INVALID,   1'b0, 1'b0, 8'h00, 1'b0}},
        '{1'b1, '{CMD_RECORD, 8'hFF, 8'd5, 8'd5, 32'd60},
              '{ST_INVALID,   1'b0, 1'b0, 8'h00, 1'b0}},
        // largest total: first and last chunk, total mismatch, duplicate
        '{1'b0, '{CMD_RECORD, 8'hFF, 8'd0, 8'd128, 32'd200},   NO_RSP},
        '{1'b0, '{CMD_RECORD, 8'hFF, 8'd127, 8'd128, 32'd200}, NO_RSP},
        '{1'b0, '{CMD_RECORD, 8'hFF, 8'd1, 8'd4, 32'd210},     NO_RSP},
        '{1'b0, '{CMD_RECORD, 8'hFF, 8'd0, 8'd128, 32'd220},   NO_RSP},
        // rewind past the known total, then to its last chunk
        '{1'b0, '{CMD_RESEND, 8'h00, 8'd128, 8'h00, 32'd250},  NO_RSP},
        '{1'b0, '{CMD_RESEND, 8'h00, 8'd127, 8'h00, 32'd300},  NO_RSP},
        '{1'b0, '{CMD_NOTE,   8'h00, 8'h00, 8'h00, 32'd0},     NO_RSP},
        '{1'b1, '{CMD_CLEAR,  8'h00, 8'h00, 8'h00, 32'd400},
              '{ST_OK,        1'b0, 1'b0, 8'h00, 1'b0}},
        // id 0 at the top of time: rewind with total unknown, then a
        // one-chunk transfer that completes, and its duplicate
        '{1'b0, '{CMD_BEGIN,  8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF}, NO_RSP},
        '{1'b0, '{CMD_RESEND, 8'h00, 8'hFF, 8'h00, 32'hFFFF_FFFF}, NO_RSP},
        '{1'b0, '{CMD_RECORD, 8'h00, 8'd0, 8'd1, 32'd0},           NO_RSP},
        '{1'b0, '{CMD_RECORD, 8'h00, 8'd0, 8'd1, 32'd5},           NO_RSP},
        '{1'b0, '{CMD_POLL,   8'h00, 8'h00, 8'h00, 32'd6},         NO_RSP},
        '{1'b1, '{CMD_CLEAR,  8'h00, 8'h00, 8'h00, 32'd7},
              '{ST_OK,        1'b0, 1'b0, 8'h00, 1'b0}}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [TIME_W-1:0] cfg_wr_data;

    crt_req_if req_ch ();
    crt_rsp_if rsp_ch ();

    chunk_reassembly_tracker #(
        .MAX_CHUNKS (N_CHUNKS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // Tracker mirror: the transfer state as the block should hold it.
    logic                trk_active;
    logic [ID_W-1:0]     trk_request;
    logic [IDX_W8-1:0]   trk_total;      // 0 while the total is not known
    logic [IDX_W8-1:0]   trk_next;
    logic [N_CHUNKS-1:0] trk_map;
    logic [TIME_W-1:0]   trk_deadline;
    logic [TIME_W-1:0]   timeout_ms;

    // stimulus plan for the transfer being driven
    logic [ID_W-1:0]     plan_id;
    logic [IDX_W8-1:0]   plan_total;
    logic [TIME_W-1:0]   clock_ms;

    rsp_item_t           pending_results [$];
    logic                quiet;          // no idling in the last phase
    int unsigned         items_sent;
    int unsigned         results_seen;
    int unsigned         fail_count;
    int unsigned         cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop in case a handshake never comes.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic transfer_done();
        return trk_active && trk_total != 0 && trk_next >= trk_total;
    endfunction

    // Apply one command to the mirror and return the result it must produce.
    function automatic rsp_item_t track_command(input cmd_item_t c);
        rsp_item_t r;
        int        k;
        r = '0;
        r.status = ST_OK;
        case (c.command)
            CMD_BEGIN:
                if (trk_active)
                    r.status = ST_BUSY;
                else
                begin
                    trk_map      = '0;
                    trk_active   = 1'b1;
                    trk_request  = c.xfer_id;
                    trk_total    = '0;
                    trk_next     = '0;
                    trk_deadline = c.now_ms + timeout_ms;
                end
            CMD_RECORD:
                if (!trk_active)
                    r.status = ST_NO_ACTIVE;
                else if (c.xfer_id != trk_request)
                    r.status = ST_WRONG_REQ;
                else if (c.chunk_total == 0 || c.chunk_index >= c.chunk_total ||
                         int'(c.chunk_total) > N_CHUNKS)
                    r.status = ST_INVALID;
                else if (trk_total != 0 && trk_total != c.chunk_total)
                    r.status = ST_INVALID;
                else
                begin
                    trk_total = c.chunk_total;
                    if (trk_map[c.chunk_index])
                        r.status = ST_DUPLICATE;
                    else
                    begin
                        trk_map[c.chunk_index] = 1'b1;
                        r.new_chunk = 1'b1;
                    end
                    // lowest clear bit below the total, or the total itself
                    trk_next = trk_total;
                    for (k = int'(trk_total) - 1; k >= 0; k--)
                        if (!trk_map[k])
                            trk_next = IDX_W8'(k);
                    trk_deadline = c.now_ms + timeout_ms;
                    r.complete = transfer_done();
                end
            CMD_RESEND:
                if (!trk_active)
                    r.status = ST_NO_ACTIVE;
                else if (trk_total != 0 && c.chunk_index >= trk_total)
                    r.status = ST_INVALID;
                else
                begin
                    trk_next     = c.chunk_index;
                    trk_deadline = c.now_ms;
                end
            CMD_NOTE:
                if (!trk_active)
                    r.status = ST_NO_ACTIVE;
                else
                    trk_deadline = c.now_ms + timeout_ms;
            CMD_CLEAR:
            begin
                trk_active   = 1'b0;
                trk_request  = '0;
                trk_total    = '0;
                trk_next     = '0;
                trk_map      = '0;
                trk_deadline = '0;
            end
            default:
                if (!trk_active)
                    r.status = ST_NO_ACTIVE;
        endcase
        r.next_needed = trk_next;
        r.resend_due  = trk_active && !transfer_done() && c.now_ms >= trk_deadline;
        return r;
    endfunction

    // Offer one item, wait for the handshake, then log what must come back.
    // Valid stays high afterwards so back-to-back items need no extra edge.
    task automatic send_item(input cmd_item_t c, input logic typed, input rsp_item_t want);
        rsp_item_t predicted;
        if (!quiet && (items_sent / 80) % 4 != 3 && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= c.command;
        req_ch.xfer_id     <= c.xfer_id;
        req_ch.chunk_index <= c.chunk_index;
        req_ch.chunk_total <= c.chunk_total;
        req_ch.now_ms      <= c.now_ms;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = track_command(c);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Random command, mostly well-formed transfers with random content.
    // The mirror state steers it: begin when idle, record toward completion
    // when active, with broken records and stray commands mixed in.
    task automatic pick_item(output cmd_item_t c);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 31) == 0)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + $urandom_range(0, 12);
        c.command     = CMD_POLL;
        c.xfer_id     = plan_id;
        c.chunk_index = IDX_W8'($urandom_range(0, 255));
        c.chunk_total = plan_total;
        c.now_ms      = clock_ms;
        if (!trk_active)
        begin
            if (roll < 75)
            begin
                // small totals mostly; the full map now and then
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    plan_total = IDX_W8'(N_CHUNKS);
                else if (roll == 1)
                    plan_total = IDX_W8'($urandom_range(1, N_CHUNKS));
                else
                    plan_total = IDX_W8'($urandom_range(1, 10));
                plan_id   = ID_W'($urandom());
                c.command = CMD_BEGIN;
                c.xfer_id = plan_id;
            end
            else
            begin
                c.command     = CMD_W'($urandom_range(1, 7));
                c.xfer_id     = ID_W'($urandom());
                c.chunk_total = IDX_W8'($urandom());
            end
        end
        else if (transfer_done() && roll < 50)
            c.command = CMD_CLEAR;
        else if (roll < 64)
        begin
            c.command = CMD_RECORD;
            if ($urandom_range(0, 1) == 0 && trk_next < plan_total)
                c.chunk_index = trk_next;
            else
                c.chunk_index = IDX_W8'($urandom_range(0, int'(plan_total) - 1));
        end
        else if (roll < 72)
        begin
            // broken record: maybe a stray id and/or total, index anywhere
            c.command = CMD_RECORD;
            if ($urandom_range(0, 1) == 0)
                c.xfer_id = ID_W'($urandom());
            if ($urandom_range(0, 1) == 0)
                c.chunk_total = IDX_W8'($urandom());
        end
        else if (roll < 78)
        begin
            c.command = CMD_RESEND;
            if ($urandom_range(0, 3) != 0)
                c.chunk_index = IDX_W8'($urandom_range(0, int'(plan_total) - 1));
        end
        else if (roll < 84)
            c.command = CMD_NOTE;
        else if (roll < 88)
            c.command = CMD_POLL;
        else if (roll < 91)
        begin
            c.command = CMD_BEGIN;
            c.xfer_id = ID_W'($urandom());
        end
        else if (roll < 96)
            c.command = CMD_CLEAR;
        else
            c.command = ($urandom_range(0, 1) == 0) ? CMD_SPARE6 : CMD_SPARE7;
    endtask

    // Result side: random stalls, calm windows, and one long hold-off that
    // backs the block up until it stops taking commands.
    initial
    begin : result_sink
        int unsigned stall_left;
        logic        held;
        stall_left = 0;
        held       = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= HOLD_AT_RESULT)
            begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !quiet && (results_seen / 80) % 4 != 1 &&
                     $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 5);
            if (stall_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Compare every accepted result with the oldest expectation.
    initial
    begin
        results_seen = 0;
        fail_count   = 0;
    end

    always @(posedge clk)
    begin : result_check
        rsp_item_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d next_needed %0d",
                       rsp_ch.status, rsp_ch.next_needed);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.complete !== want.complete)
                begin
                    $error("complete: expected %0d, got %0d", want.complete, rsp_ch.complete);
                    fail_count++;
                end
                if (rsp_ch.new_chunk !== want.new_chunk)
                begin
                    $error("new_chunk: expected %0d, got %0d", want.new_chunk,
                           rsp_ch.new_chunk);
                    fail_count++;
                end
                if (rsp_ch.next_needed !== want.next_needed)
                begin
                    $error("next_needed: expected %0d, got %0d", want.next_needed,
                           rsp_ch.next_needed);
                    fail_count++;
                end
                if (rsp_ch.resend_due !== want.resend_due)
                begin
                    $error("resend_due: expected %0d, got %0d", want.resend_due,
                           rsp_ch.resend_due);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        cmd_item_t         c;
        logic [TIME_W-1:0] tmo;
        int                ph;
        int                n;

        req_ch.valid       <= 1'b0;
        req_ch.command     <= CMD_POLL;
        req_ch.xfer_id     <= '0;
        req_ch.chunk_index <= '0;
        req_ch.chunk_total <= '0;
        req_ch.now_ms      <= '0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;

        trk_active   = 1'b0;
        trk_request  = '0;
        trk_total    = '0;
        trk_next     = '0;
        trk_map      = '0;
        trk_deadline = '0;
        timeout_ms   = '0;
        plan_id      = '0;
        plan_total   = 8'd1;
        clock_ms     = '0;
        quiet        = 1'b0;
        items_sent   = 0;

        @(posedge rst_n);
        @(posedge clk);

        for (n = 0; n < $size(DIRECTED); n++)
            send_item(DIRECTED[n].cmd, DIRECTED[n].typed, DIRECTED[n].want);

        // Random phases, each behind a timeout write made while idle.
        // Both extremes of the timeout are covered; one phase starts the
        // clock just below the wrap point.
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            req_ch.valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            case (ph)
                0:       tmo = 32'hFFFF_FFFF;
                1:       tmo = TIME_W'($urandom_range(1, 40));
                2:       tmo = '0;
                3:       tmo = 32'h8000_0000;
                4:       tmo = $urandom();
                default: tmo = TIME_W'($urandom_range(0, 15));
            endcase
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= tmo;
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
            timeout_ms   = tmo;
            clock_ms     = (ph == 1) ? 32'hFFFF_FF00 : $urandom();
            quiet        = (ph == N_PHASES - 1);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick_item(c);
                send_item(c, 1'b0, NO_RSP);
            end
        end

        // Drain, then idle the bench so the block can show anything stray.
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
